// ----- rtl/sfrf_pkg.sv -----
// Shared types and constants for the S-Bus frame repeater with failsafe.
// Used by sfrf_ctrl, sfrf_dpath and sbus_frame_repeater_failsafe.
package sfrf_pkg;

  localparam int IDX_W       = 5;
  localparam int BANK_AW     = IDX_W + 1;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 80;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 16;
  localparam int TIMER_W     = 16;
  localparam int CNT_W       = 32;
  localparam int CH_W        = 11;

  localparam logic [IDX_W-1:0] FRAME_LEN  = 5'd25;
  localparam logic [IDX_W-1:0] FRAME_LAST = 5'd24;
  localparam logic [IDX_W-1:0] FLAGS_IDX  = 5'd23;
  localparam logic [IDX_W-1:0] NUM_CH     = 5'd16;
  localparam logic [7:0]       HEADER     = 8'h0F;
  localparam logic [7:0]       FOOTER     = 8'h00;
  localparam logic [7:0]       LOST_FLAGS = 8'h04;
  localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;

  typedef enum logic [CFG_AW-1:0] {
    REG_TIMEOUT     = 2'd0,
    REG_SAFE_PERIOD = 2'd1,
    REG_CENTER      = 2'd2,
    REG_CENTERED_CH = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EMIT = 3'b010,
    ST_STAT = 3'b100
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic             fire;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             ld;
    logic             ld_stat;
    logic             fs_mode;
  } cmd_t;

  // datapath -> controller, valid in the accept cycle
  typedef struct packed {
    logic frame_good;
    logic fs_go;
    logic stat_go;
  } stat_t;

endpackage

// ----- rtl/sfrf_ctrl.sv -----
// Controller: accepts items, sequences frame read-out and result loads.
// Depends on sfrf_pkg; drives sfrf_dpath through cmd_t, reads stat_t.
module sfrf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  sfrf_pkg::stat_t stat,
  output sfrf_pkg::cmd_t  cmd
);
  import sfrf_pkg::*;

  state_t           state_r, state_nxt;
  logic             fs_mode_r, fs_mode_nxt;
  logic [IDX_W-1:0] iss_cnt_r, iss_cnt_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic             out_v_r, out_v_nxt;

  logic in_fire, take, ld, iss, ld_stat, done;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign take       = out_v_r && out_tready;

  assign ld      = (state_r == ST_EMIT) && rd_v_r && (!out_v_r || take);
  assign iss     = (state_r == ST_EMIT) && (iss_cnt_r < FRAME_LEN) && (!rd_v_r || ld);
  assign done    = ld && (iss_cnt_r == FRAME_LEN);
  assign ld_stat = (state_r == ST_STAT) && (!out_v_r || take);

  assign cmd.fire    = in_fire;
  assign cmd.rd_en   = iss;
  assign cmd.rd_idx  = iss_cnt_r;
  assign cmd.ld      = ld;
  assign cmd.ld_stat = ld_stat;
  assign cmd.fs_mode = fs_mode_r;

  always_comb begin
    state_nxt   = state_r;
    fs_mode_nxt = fs_mode_r;
    iss_cnt_nxt = iss ? iss_cnt_r + 5'd1 : iss_cnt_r;
    rd_v_nxt    = iss ? 1'b1 : (ld ? 1'b0 : rd_v_r);
    out_v_nxt   = (ld || ld_stat) ? 1'b1 : (take ? 1'b0 : out_v_r);
    case (state_r)
      ST_IDLE: begin
        if (in_fire && stat.frame_good) begin
          state_nxt   = ST_EMIT;
          fs_mode_nxt = 1'b0;
          iss_cnt_nxt = '0;
        end else if (in_fire && stat.fs_go) begin
          state_nxt   = ST_EMIT;
          fs_mode_nxt = 1'b1;
          iss_cnt_nxt = '0;
        end else if (in_fire && stat.stat_go) begin
          state_nxt = ST_STAT;
        end
      end
      ST_EMIT: begin
        if (done) state_nxt = ST_IDLE;
      end
      ST_STAT: begin
        if (ld_stat) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fs_mode_r <= 1'b0;
      iss_cnt_r <= '0;
      rd_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fs_mode_r <= fs_mode_nxt;
      iss_cnt_r <= iss_cnt_nxt;
      rd_v_r    <= rd_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  a_read_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (state_r == ST_EMIT))
    else $error("read stage busy outside frame emission");

  a_no_stuck_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !((state_r == ST_EMIT) && (iss_cnt_r == FRAME_LEN) && !rd_v_r))
    else $error("emission has no byte left but did not finish");

  a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (stat.frame_good || stat.fs_go)) |=>
      ((state_r == ST_EMIT) && (iss_cnt_r == '0) && !rd_v_r))
    else $error("frame emission did not start cleanly");

  a_stat_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> $onehot0({stat.frame_good, stat.fs_go, stat.stat_go}))
    else $error("item decoded to more than one outcome");

endmodule

// ----- rtl/sfrf_dpath.sv -----
// Datapath: config registers, framing, ping-pong frame store, timers,
// counters, failsafe byte builder and the output register. Uses sfrf_pkg.
module sfrf_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [sfrf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [sfrf_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_op,
  input  logic [7:0]                 in_byte,
  input  sfrf_pkg::cmd_t             cmd,
  output sfrf_pkg::stat_t            stat,
  output logic [7:0]                 out_byte,
  output logic                       out_byte_valid,
  output logic                       out_last,
  output logic                       out_failsafe,
  output logic                       out_flowing,
  output logic [sfrf_pkg::CNT_W-1:0] out_good,
  output logic [sfrf_pkg::CNT_W-1:0] out_bad
);
  import sfrf_pkg::*;

  // configuration
  logic [TIMER_W-1:0] timeout_r, safe_r;
  logic [CH_W-1:0]    center_r;
  logic [IDX_W-1:0]   ccount_r;

  // framing and status state
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               wbank_r, wbank_nxt;
  logic               have_last_r, have_last_nxt;
  logic [TIMER_W-1:0] sf_r, sf_nxt, ss_r, ss_nxt;
  logic [CNT_W-1:0]   good_r, good_nxt, bad_r, bad_nxt;

  // frame store, two banks of 32
  logic [7:0] mem [2**BANK_AW];
  logic [7:0]       rdata_r;
  logic [IDX_W-1:0] ridx_r;

  // bit position of the current failsafe byte within the channel stream
  logic [3:0] ch_r, ch_nxt;
  logic [3:0] pos_r, pos_nxt;

  // output payload
  logic [7:0]       ob_r;
  logic             bv_r, last_r, fs_r, flow_r;
  logic [CNT_W-1:0] og_r, obad_r;

  logic               wr, complete, good, tick, fs_cond;
  logic [TIMER_W-1:0] sf_inc, ss_inc;
  logic [IDX_W-1:0]   n_cent;
  logic [7:0]         fs_byte, ld_byte;
  logic               mid_byte;

  // --- configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 16'd500;
      safe_r    <= 16'd14;
      center_r  <= 11'd1024;
      ccount_r  <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_TIMEOUT:     timeout_r <= cfg_wdata;
        REG_SAFE_PERIOD: safe_r    <= cfg_wdata;
        REG_CENTER:      center_r  <= cfg_wdata[CH_W-1:0];
        REG_CENTERED_CH: ccount_r  <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // --- item decode
  assign wr       = cmd.fire && !in_op && ((cnt_r != '0) || (in_byte == HEADER));
  assign complete = wr && (cnt_r == FRAME_LAST);
  assign good     = complete && (in_byte == FOOTER);
  assign tick     = cmd.fire && in_op;
  assign sf_inc   = (sf_r == TIMER_MAX) ? sf_r : sf_r + 16'd1;
  assign ss_inc   = (ss_r == TIMER_MAX) ? ss_r : ss_r + 16'd1;
  assign fs_cond  = !(sf_inc < timeout_r) && (ss_inc >= safe_r);

  assign stat.frame_good = good;
  assign stat.fs_go      = tick && fs_cond;
  assign stat.stat_go    = tick && !fs_cond;

  always_comb begin
    cnt_nxt       = complete ? '0 : (wr ? cnt_r + 5'd1 : cnt_r);
    wbank_nxt     = good ? ~wbank_r : wbank_r;
    have_last_nxt = have_last_r || good;
    good_nxt      = good ? good_r + 32'd1 : good_r;
    bad_nxt       = (complete && !good) ? bad_r + 32'd1 : bad_r;
    sf_nxt        = good ? '0 : (tick ? sf_inc : sf_r);
    ss_nxt        = tick ? (fs_cond ? '0 : ss_inc) : ss_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      wbank_r     <= 1'b0;
      have_last_r <= 1'b0;
      good_r      <= '0;
      bad_r       <= '0;
      sf_r        <= '0;
      ss_r        <= '0;
    end else begin
      cnt_r       <= cnt_nxt;
      wbank_r     <= wbank_nxt;
      have_last_r <= have_last_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      sf_r        <= sf_nxt;
      ss_r        <= ss_nxt;
    end
  end

  // --- frame store: write the assembling bank, read the last good bank
  always_ff @(posedge clk) begin
    if (wr) mem[{wbank_r, cnt_r}] <= in_byte;
    if (cmd.rd_en) begin
      rdata_r <= mem[{~wbank_r, cmd.rd_idx}];
      ridx_r  <= cmd.rd_idx;
    end
  end

  // --- failsafe byte: per bit, centre value or the last frame's bit
  assign n_cent   = (ccount_r > NUM_CH) ? NUM_CH : ccount_r;
  assign mid_byte = (ridx_r != '0) && (ridx_r < FLAGS_IDX);

  always_comb begin
    logic [4:0] p;
    logic [4:0] chan;
    logic [3:0] cbit;
    fs_byte = '0;
    for (int b = 0; b < 8; b++) begin
      p    = {1'b0, pos_r} + 5'(b);
      chan = (p >= 5'd11) ? {1'b0, ch_r} + 5'd1 : {1'b0, ch_r};
      cbit = (p >= 5'd11) ? 4'(p - 5'd11) : p[3:0];
      fs_byte[b] = ((chan < n_cent) || !have_last_r) ? center_r[cbit] : rdata_r[b];
    end
  end

  always_comb begin
    logic [4:0] pa;
    pa      = {1'b0, pos_r} + 5'd8;
    pos_nxt = pos_r;
    ch_nxt  = ch_r;
    if (cmd.fire) begin
      pos_nxt = '0;
      ch_nxt  = '0;
    end else if (cmd.ld && mid_byte) begin
      // advance one byte through the 11-bit channel stream
      if (pa >= 5'd11) begin
        pos_nxt = 4'(pa - 5'd11);
        ch_nxt  = ch_r + 4'd1;
      end else begin
        pos_nxt = pa[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r  <= ch_nxt;
    pos_r <= pos_nxt;
  end

  always_comb begin
    ld_byte = rdata_r;
    if (cmd.fs_mode) begin
      if (ridx_r == '0)             ld_byte = HEADER;
      else if (ridx_r == FLAGS_IDX) ld_byte = LOST_FLAGS;
      else if (ridx_r == FRAME_LAST) ld_byte = FOOTER;
      else                          ld_byte = fs_byte;
    end
  end

  // --- output register
  always_ff @(posedge clk) begin
    if (cmd.ld || cmd.ld_stat) begin
      flow_r <= (sf_r < timeout_r);
      og_r   <= good_r;
      obad_r <= bad_r;
    end
    if (cmd.ld) begin
      ob_r   <= ld_byte;
      bv_r   <= 1'b1;
      last_r <= (ridx_r == FRAME_LAST);
      fs_r   <= cmd.fs_mode;
    end else if (cmd.ld_stat) begin
      ob_r   <= '0;
      bv_r   <= 1'b0;
      last_r <= 1'b1;
      fs_r   <= 1'b0;
    end
  end

  assign out_byte       = ob_r;
  assign out_byte_valid = bv_r;
  assign out_last       = last_r;
  assign out_failsafe   = fs_r;
  assign out_flowing    = flow_r;
  assign out_good       = og_r;
  assign out_bad        = obad_r;

endmodule

// ----- rtl/sbus_frame_repeater_failsafe.sv -----
// S-Bus frame repeater with failsafe. Bytes that cause no result are taken one per cycle.
// A tick with a status result loads it into the output register once that register is free;
// the next item is taken after the load. A 25-byte frame (forwarded or failsafe) streams one
// byte per cycle while out_tready is high, after a start through the store read and the
// output register; the next item is taken once its last byte is loaded. Reset (rst_n, sync,
// active low) clears control, timers, counters, config; not the frame store. Uses sfrf_pkg.
module sbus_frame_repeater_failsafe (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sfrf_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [sfrf_pkg::CFG_DW-1:0]      cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sfrf_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] in_byte
  input  logic                             in_tuser,   // [0] op
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sfrf_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] out_byte, [8] flowing,
                                                       // [40:9] good_frames, [72:41] bad_frames
  output logic [1:0]                       out_tuser,  // [0] byte_valid, [1] failsafe
  output logic                             out_tlast   // last_of_run
);
  import sfrf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic [7:0]       out_byte;
  logic             out_byte_valid, out_failsafe, out_flowing;
  logic [CNT_W-1:0] out_good, out_bad;

  sfrf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sfrf_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_op          (in_tuser),
    .in_byte        (in_tdata[7:0]),
    .cmd            (cmd),
    .stat           (stat),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_tlast),
    .out_failsafe   (out_failsafe),
    .out_flowing    (out_flowing),
    .out_good       (out_good),
    .out_bad        (out_bad)
  );

  assign out_tdata = {7'd0, out_bad, out_good, out_flowing, out_byte};
  assign out_tuser = {out_failsafe, out_byte_valid};

endmodule
